// ----- rtl/glcd_pkg.sv -----
// Shared constants for the graphic LCD pixel set block.
package glcd_pkg;

  localparam int unsigned FsDepth = 512;
  localparam int unsigned FsAw    = 9;
  localparam int unsigned WordW   = 16;

  localparam logic [7:0]       CmdBase = 8'h80;
  localparam logic [WordW-1:0] PixMsb  = 16'h8000;

endpackage

// ----- rtl/glcd_ram.sv -----
// Generic simple dual-port RAM with registered read.
module glcd_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/graphic_lcd_pixel_set_core.sv -----
// Pixel set core: 128x64 frame store and four-byte controller transaction per pixel.
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------
//  pixel   | start_i / busy_o   | x_coord_i[7:0], y_coord_i[7:0], merge_mode_i
//  bytes   | strobe_o (no stall)| is_data_o, bus_byte_o[7:0], last_byte_o
//
// Every pixel yields exactly four bytes on consecutive cycles, starting
// the cycle after acceptance. busy_o drops during the fourth byte, so a new
// pixel can be taken then and pixels stream back to back; their rate is
// set by the one-byte-per-cycle result port.
// After reset a clearing pass zeroes the 512-word store, one word per cycle,
// with busy_o high. The receiver cannot stall the byte stream.
module graphic_lcd_pixel_set_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [7:0] x_coord_i,
  input  logic [7:0] y_coord_i,
  input  logic       merge_mode_i,
  output logic       strobe_o,
  output logic       is_data_o,
  output logic [7:0] bus_byte_o,
  output logic       last_byte_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CMD0,
    ST_CMD1,
    ST_DHI,
    ST_DLO
  } state_e;

  state_e state_q, state_d;

  logic [glcd_pkg::FsAw-1:0]  clr_q, clr_d;
  logic [5:0]                 row_q;     // unfolded row, 63 - (y mod 64)
  logic [2:0]                 col_q;     // column word, (x mod 128) / 16
  logic [3:0]                 bit_q;     // x mod 16
  logic                       merge_q;
  logic [glcd_pkg::WordW-1:0] word_q, word_d;

  logic                       accept;
  logic [5:0]                 in_row;
  logic [glcd_pkg::FsAw-1:0]  rd_addr;
  logic [glcd_pkg::FsAw-1:0]  wr_addr;
  logic [glcd_pkg::WordW-1:0] wr_data;
  logic                       wr_en;
  logic [glcd_pkg::WordW-1:0] rd_data;
  logic [glcd_pkg::WordW-1:0] pix_bit;

  // Accept while idle, or during the last byte of the previous transaction.
  assign busy_o = !(state_q == ST_IDLE || state_q == ST_DLO);
  assign accept = start_i && !busy_o;

  // Origin is at the bottom: unfolded row is 63 - (y mod 64).
  assign in_row  = ~y_coord_i[5:0];
  assign rd_addr = {in_row, x_coord_i[6:4]};

  assign pix_bit = glcd_pkg::PixMsb >> bit_q;

  // Read-modify-write: the read issued at acceptance returns in ST_CMD0,
  // where the merged word is written back. The next read to the same word
  // is issued no earlier than ST_DLO, so no forwarding is needed.
  always_comb begin
    word_d = word_q;
    if (state_q == ST_CMD0) begin
      word_d = merge_q ? (pix_bit | rd_data) : pix_bit;
    end
  end

  always_comb begin
    if (state_q == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_q;
      wr_data = '0;
    end else begin
      wr_en   = (state_q == ST_CMD0) && merge_q;
      wr_addr = {row_q, col_q};
      wr_data = word_d;
    end
  end

  glcd_ram #(
    .Width (glcd_pkg::WordW),
    .Depth (glcd_pkg::FsDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE:  state_d = accept ? ST_CMD0 : ST_IDLE;
      ST_CMD0:  state_d = ST_CMD1;
      ST_CMD1:  state_d = ST_DHI;
      ST_DHI:   state_d = ST_DLO;
      ST_DLO:   state_d = accept ? ST_CMD0 : ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q   <= in_row;
      col_q   <= x_coord_i[6:4];
      bit_q   <= x_coord_i[3:0];
      merge_q <= merge_mode_i;
    end
    word_q <= word_d;
  end

  // Byte decode. Rows 32..63 sit in the lower half: column gets +8.
  always_comb begin
    strobe_o    = 1'b1;
    is_data_o   = 1'b0;
    last_byte_o = 1'b0;
    bus_byte_o  = '0;
    unique case (state_q)
      ST_CMD0: bus_byte_o = glcd_pkg::CmdBase | {3'b000, row_q[4:0]};
      ST_CMD1: bus_byte_o = glcd_pkg::CmdBase | {4'b0000, row_q[5], col_q};
      ST_DHI: begin
        is_data_o  = 1'b1;
        bus_byte_o = word_q[15:8];
      end
      ST_DLO: begin
        is_data_o   = 1'b1;
        last_byte_o = 1'b1;
        bus_byte_o  = word_q[7:0];
      end
      default: strobe_o = 1'b0;
    endcase
  end

  // An accepted pixel is followed by its first command byte.
  a_first_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> strobe_o && !is_data_o && !last_byte_o)
    else $error("first byte missing after acceptance");

  // The last byte follows the high data byte.
  a_last_after_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_byte_o |-> $past(strobe_o) && $past(is_data_o) && !$past(last_byte_o))
    else $error("last byte not preceded by high data byte");

  // Store writes outside clearing only happen on the merge word-back.
  a_write_only_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && state_q != ST_CLEAR) |-> (state_q == ST_CMD0 && merge_q))
    else $error("unexpected store write");

  // No bytes are emitted during the clearing pass.
  a_quiet_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (busy_o && !strobe_o))
    else $error("activity during clearing pass");

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for graphic_lcd_pixel_set_core: pixel transactions in, byte stream out.
module tb_top;

  // No result for this long (in cycles) means the block is stuck. It covers
  // the clearing pass after reset plus generous margin.
  localparam int unsigned HangLimit = 4000;
  localparam int unsigned RandItems = 358;

  // One controller byte as it shows up on the byte port.
  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last_byte;
  } ctrl_byte_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       start_i      = 1'b0;
  logic [7:0] x_coord_i    = '0;
  logic [7:0] y_coord_i    = '0;
  logic       merge_mode_i = 1'b0;
  logic       busy_o;
  logic       strobe_o;
  logic       is_data_o;
  logic [7:0] bus_byte_o;
  logic       last_byte_o;

  // Shadow of the frame store, kept in step with every accepted pixel.
  logic [glcd_pkg::WordW-1:0] shadow_store [glcd_pkg::FsDepth];
  // Bytes the block still owes, oldest first.
  ctrl_byte_t                 pending_bytes [$];

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  // When set, the sender never idles between pixels.
  bit          back_to_back   = 1'b0;

  graphic_lcd_pixel_set_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .x_coord_i   (x_coord_i),
    .y_coord_i   (y_coord_i),
    .merge_mode_i(merge_mode_i),
    .strobe_o    (strobe_o),
    .is_data_o   (is_data_o),
    .bus_byte_o  (bus_byte_o),
    .last_byte_o (last_byte_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Work out the four controller bytes for one accepted pixel and, on a merge,
  // update the shadow store. Wrap is free: only the low 7 bits of X and 6 bits of Y count.
  function automatic void predict_pixel_bytes(input logic [7:0] x, input logic [7:0] y,
                                              input logic merge);
    logic [6:0]                 px;
    logic [5:0]                 row;
    logic [2:0]                 col;
    logic [glcd_pkg::FsAw-1:0]  addr;
    logic [glcd_pkg::WordW-1:0] word;
    ctrl_byte_t                 b;
    px   = x[6:0];
    row  = 6'd63 - y[5:0];         // origin at the bottom, so rows count down
    col  = px[6:4];
    addr = {row, col};
    word = glcd_pkg::PixMsb >> px[3:0];
    if (merge) begin
      word = word | shadow_store[addr];
      shadow_store[addr] = word;
    end
    // Lower half of the panel (unfolded rows 32..63) sits at column words 8..15.
    b = '{1'b0, glcd_pkg::CmdBase + {3'b000, row[4:0]}, 1'b0};
    pending_bytes.push_back(b);
    b = '{1'b0, glcd_pkg::CmdBase + {4'b0000, row[5], col}, 1'b0};
    pending_bytes.push_back(b);
    b = '{1'b1, word[15:8], 1'b0};
    pending_bytes.push_back(b);
    b = '{1'b1, word[7:0], 1'b1};
    pending_bytes.push_back(b);
  endfunction

  // Send one pixel. start_i stays high from one transaction into the next when
  // there is no gap, so it never gets two updates in the same time step.
  task automatic send_pixel(input logic [7:0] x, input logic [7:0] y, input logic merge);
    int unsigned gap;
    gap = back_to_back ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      if (start_i) start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    x_coord_i    <= x;
    y_coord_i    <= y;
    merge_mode_i <= merge;
    do @(posedge clk_i); while (busy_o);
    predict_pixel_bytes(x, y, merge);
  endtask

  // Byte checker: the receiver can't stall, so every strobe is one byte.
  always @(posedge clk_i) begin
    ctrl_byte_t want;
    if (rst_ni && strobe_o) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch("unexpected byte", bus_byte_o, 0);
      end else begin
        want = pending_bytes.pop_front();
        if (is_data_o !== want.is_data) report_mismatch("is_data", is_data_o, want.is_data);
        if (bus_byte_o !== want.bus_byte) report_mismatch("bus_byte", bus_byte_o, want.bus_byte);
        if (last_byte_o !== want.last_byte)
          report_mismatch("last_byte", last_byte_o, want.last_byte);
      end
    end
  end

  // Hang detector: counts cycles with neither an accepted pixel nor a byte.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || strobe_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < HangLimit) @(posedge clk_i);
    $display("timeout: no activity for %0d cycles", HangLimit);
    $display("*** FAILED ***");
    $finish;
  end

  // Corners of the panel on a freshly cleared store, with and without merge.
  task automatic test_corners;
    back_to_back = 1'b0;
    send_pixel(8'd0,   8'd0,   1'b1);   // bottom-left, lower half of the unfolded rows
    send_pixel(8'd127, 8'd63,  1'b1);   // top-right, upper half
    send_pixel(8'd255, 8'd255, 1'b0);   // both coordinates wrap, lone bit
    send_pixel(8'd128, 8'd64,  1'b1);   // wraps onto the first pixel's word
  endtask

  // Lone bit on words that already hold bits: the store must not be touched,
  // which the later merge into the first of those words would expose.
  task automatic test_lone_bit;
    back_to_back = 1'b1;
    send_pixel(8'd1,   8'd0,  1'b0);
    send_pixel(8'd126, 8'd63, 1'b0);
    send_pixel(8'd2,   8'd64, 1'b1);
  endtask

  // Walk all sixteen bit positions of one word, merging, so it fills to 0xFFFF.
  task automatic test_bit_positions;
    for (int i = 0; i < 16; i++) begin
      back_to_back = (i < 8);
      send_pixel(8'(16 + i), 8'(10 + 64 * (i % 4)), 1'b1);
    end
  endtask

  // Random pixels. Most land in a small patch of words so merges pile up on
  // words that already hold bits; the rest are spread over the whole range.
  task automatic test_random;
    logic [7:0] x;
    logic [7:0] y;
    logic [2:0] patch_col;
    logic [5:0] patch_row;
    for (int unsigned n = 0; n < RandItems; n++) begin
      if (n % 20 == 0) begin
        back_to_back = ($urandom_range(0, 2) == 0);
        patch_col    = 3'($urandom_range(0, 7));
        patch_row    = 6'($urandom_range(0, 60));
      end
      if ($urandom_range(0, 9) < 6) begin
        x = {$urandom_range(0, 1) ? 1'b1 : 1'b0, patch_col, 4'($urandom_range(0, 15))};
        y = {2'($urandom_range(0, 3)), patch_row + 6'($urandom_range(0, 3))};
      end else begin
        x = 8'($urandom_range(0, 255));
        y = 8'($urandom_range(0, 255));
      end
      send_pixel(x, y, $urandom_range(0, 3) != 0);
    end
  endtask

  initial begin
    foreach (shadow_store[i]) shadow_store[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_corners();
    test_lone_bit();
    test_bit_positions();
    test_random();
    start_i <= 1'b0;

    // Drain the byte stream, then watch a few more cycles for stray strobes.
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/glcd_pkg.sv
rtl/glcd_ram.sv
rtl/graphic_lcd_pixel_set_core.sv
test/tb_top.sv
